// File: rtl/core/multidim_array_address_generator_unit_macros.svh
// Assertion helpers used by the address generator controller
`ifndef MULTIDIM_ARRAY_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define MULTIDIM_ARRAY_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define MAAG_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the following cycle
`define MAAG_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/maag_pkg.sv
package maag_pkg;

	// Default sizing
	localparam int NUM_SLOTS_DEF = 16;
	localparam int MAX_DIMS_DEF  = 16;

	// Field widths
	localparam int BASE_W  = 31;
	localparam int ESIZE_W = 16;
	localparam int DIMS_W  = 5;
	localparam int HDR_W   = BASE_W + ESIZE_W + DIMS_W;

	// Opcodes
	localparam logic [1:0] OP_HDR = 2'd0;
	localparam logic [1:0] OP_BND = 2'd1;
	localparam logic [1:0] OP_CMT = 2'd2;
	localparam logic [1:0] OP_IDX = 2'd3;

	// Decoded kind of an incoming word, after range checks
	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_HDR,
		KIND_BND,
		KIND_CMT,
		KIND_IDX
	} item_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic cmt_load;
		logic cmt_lo;
		logic cmt_step;
		logic idx_mul;
		logic idx_acc;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		item_kind_t kind;
		logic       idx_live;
		logic       idx_last;
		logic       walk_end;
	} dp_status_t;

endpackage

// File: rtl/core/maag_ram.sv
module maag_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/maag_dpath.sv
module maag_dpath #(
	parameter int NUM_SLOTS = maag_pkg::NUM_SLOTS_DEF,
	parameter int MAX_DIMS  = maag_pkg::MAX_DIMS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           opcode,
	input  logic [3:0]           slot,
	input  logic [3:0]           dim_position,
	input  logic [30:0]          base_address,
	input  logic [15:0]          elem_size,
	input  logic [4:0]           dim_count,
	input  logic [15:0]          lower_bound,
	input  logic [15:0]          upper_bound,
	input  logic [15:0]          index_value,
	input  maag_pkg::dp_cmd_t    cmd,
	output maag_pkg::dp_status_t st,
	output logic [31:0]          address
);

	localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int TAB_D   = NUM_SLOTS * MAX_DIMS;
	localparam int TAB_AW  = (TAB_D > 1) ? $clog2(TAB_D) : 1;

	function automatic logic [TAB_AW-1:0] row_addr(input logic [3:0] s, input logic [3:0] p);
		logic [31:0] a;
		a = 32'(s) * 32'(MAX_DIMS) + 32'(p);
		return a[TAB_AW-1:0];
	endfunction

	function automatic logic [SLOT_AW-1:0] slot_addr(input logic [3:0] s);
		logic [31:0] a;
		a = 32'(s);
		return a[SLOT_AW-1:0];
	endfunction

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	maag_pkg::item_kind_t kind;
	logic                 slot_ok;
	logic                 pos_ok;
	logic [4:0]           dims_sat;

	// Captured item fields
	logic [3:0]  slot_q;
	logic [3:0]  pos_q;
	logic [15:0] index_q;

	// Commit walk and accumulate registers
	logic [31:0] st_q;
	logic [31:0] off_q;
	logic [3:0]  i_q;
	logic [31:0] prod_q;
	logic [31:0] extent_q;
	logic        last_q;
	logic        pos0_q;
	logic [31:0] run_q;
	logic [31:0] addr_q;

	// Memory ports
	logic                          hdr_we, hdr_re;
	logic [maag_pkg::HDR_W-1:0]    hdr_wd, hdr_rd;
	logic                          bnd_we, bnd_re;
	logic [TAB_AW-1:0]             bnd_waddr, walk_addr;
	logic [31:0]                   bnd_wd, bnd_rd;
	logic                          str_we, str_re;
	logic [31:0]                   str_wd, str_rd;
	logic                          off_we, off_re;
	logic [31:0]                   off_wd, off_rd;

	logic [maag_pkg::BASE_W-1:0]   base_rd;
	logic [maag_pkg::ESIZE_W-1:0]  esize_rd;
	logic [maag_pkg::DIMS_W-1:0]   dims_rd;
	logic [4:0]                    dims_m1;
	logic [31:0]                   mul_a, mul_b, mul_p;
	logic [31:0]                   next_st;
	logic [31:0]                   acc_sum;

	// Decode the word and check its slot and dimension ranges
	always_comb begin
		slot_ok = 32'(slot) < NUM_SLOTS;
		pos_ok  = 32'(dim_position) < MAX_DIMS;
		unique case (opcode)
			maag_pkg::OP_HDR: kind = slot_ok ? maag_pkg::KIND_HDR : maag_pkg::KIND_NONE;
			maag_pkg::OP_BND: kind = (slot_ok && pos_ok) ? maag_pkg::KIND_BND
				: maag_pkg::KIND_NONE;
			maag_pkg::OP_CMT: kind = slot_ok ? maag_pkg::KIND_CMT : maag_pkg::KIND_NONE;
			maag_pkg::OP_IDX: kind = (slot_ok && pos_ok) ? maag_pkg::KIND_IDX
				: maag_pkg::KIND_NONE;
			default: kind = maag_pkg::KIND_NONE;
		endcase
	end

	// Saturate the dimension count into its legal range
	always_comb begin
		if (dim_count == 5'd0) begin
			dims_sat = 5'd1;
		end else if (32'(dim_count) > MAX_DIMS) begin
			dims_sat = 5'(MAX_DIMS);
		end else begin
			dims_sat = dim_count;
		end
	end

	assign base_rd  = hdr_rd[maag_pkg::HDR_W-1 -: maag_pkg::BASE_W];
	assign esize_rd = hdr_rd[maag_pkg::DIMS_W +: maag_pkg::ESIZE_W];
	assign dims_rd  = hdr_rd[maag_pkg::DIMS_W-1:0];
	assign dims_m1  = dims_rd - 5'd1;

	// Shared multiplier: offset term during commit, index term otherwise
	assign mul_a   = cmd.cmt_lo ? st_q : str_rd;
	assign mul_b   = cmd.cmt_lo ? sext16(bnd_rd[31:16]) : sext16(index_q);
	assign mul_p   = mul_a * mul_b;
	assign next_st = st_q * extent_q;
	assign acc_sum = (pos0_q ? off_rd : run_q) + prod_q;

	// Memory port control
	assign walk_addr = cmd.cmt_load ? row_addr(slot_q, dims_m1[3:0])
		: row_addr(slot_q, i_q - 4'd1);
	assign bnd_waddr = row_addr(slot, dim_position);

	assign hdr_we = cmd.accept && (kind == maag_pkg::KIND_HDR);
	assign hdr_wd = {base_address, elem_size, dims_sat};
	assign hdr_re = cmd.accept && ((kind == maag_pkg::KIND_CMT) || (kind == maag_pkg::KIND_IDX));

	assign bnd_we = cmd.accept && (kind == maag_pkg::KIND_BND);
	assign bnd_wd = {lower_bound, upper_bound};
	assign bnd_re = cmd.cmt_load || (cmd.cmt_step && (i_q != 4'd0));

	assign str_we = bnd_re;
	assign str_wd = cmd.cmt_load ? {16'd0, esize_rd} : next_st;
	assign str_re = cmd.accept && (kind == maag_pkg::KIND_IDX);

	assign off_we = cmd.cmt_step && (i_q == 4'd0);
	assign off_wd = off_q - prod_q;
	assign off_re = str_re;

	maag_ram #(.WIDTH(maag_pkg::HDR_W), .DEPTH(NUM_SLOTS)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (slot_addr(slot)),
		.wdata (hdr_wd),
		.re    (hdr_re),
		.raddr (slot_addr(slot)),
		.rdata (hdr_rd)
	);

	maag_ram #(.WIDTH(32), .DEPTH(TAB_D)) u_bnd_ram (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (bnd_waddr),
		.wdata (bnd_wd),
		.re    (bnd_re),
		.raddr (walk_addr),
		.rdata (bnd_rd)
	);

	maag_ram #(.WIDTH(32), .DEPTH(TAB_D)) u_str_ram (
		.clk   (clk),
		.we    (str_we),
		.waddr (walk_addr),
		.wdata (str_wd),
		.re    (str_re),
		.raddr (row_addr(slot, dim_position)),
		.rdata (str_rd)
	);

	maag_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_off_ram (
		.clk   (clk),
		.we    (off_we),
		.waddr (slot_addr(slot_q)),
		.wdata (off_wd),
		.re    (off_re),
		.raddr (slot_addr(slot)),
		.rdata (off_rd)
	);

	// Capture item fields and advance the commit walk and accumulation
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			slot_q  <= slot;
			pos_q   <= dim_position;
			index_q <= index_value;
		end
		if (cmd.cmt_load) begin
			st_q  <= {16'd0, esize_rd};
			off_q <= {1'b0, base_rd};
			i_q   <= dims_m1[3:0];
		end
		if (cmd.cmt_lo) begin
			extent_q <= sext16(bnd_rd[15:0]) - sext16(bnd_rd[31:16]) + 32'd1;
		end
		if (cmd.cmt_lo || cmd.idx_mul) begin
			prod_q <= mul_p;
		end
		if (cmd.cmt_step) begin
			off_q <= off_wd;
			if (i_q != 4'd0) begin
				st_q <= next_st;
				i_q  <= i_q - 4'd1;
			end
		end
		if (cmd.idx_mul) begin
			last_q <= ({1'b0, pos_q} + 5'd1) == dims_rd;
			pos0_q <= pos_q == 4'd0;
		end
		if (cmd.out_load) begin
			addr_q <= acc_sum;
		end
	end

	// Hold the running address across index words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 32'd0;
		end else if (cmd.idx_acc) begin
			run_q <= acc_sum;
		end
	end

	assign st.kind     = kind;
	assign st.idx_live = {1'b0, pos_q} < dims_rd;
	assign st.idx_last = last_q;
	assign st.walk_end = i_q == 4'd0;
	assign address     = addr_q;

endmodule

// File: rtl/core/maag_ctrl.sv
`include "multidim_array_address_generator_unit_macros.svh"

module maag_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  maag_pkg::dp_status_t st,
	output maag_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_IDX,
		S_ACC,
		S_CHDR,
		S_CLO,
		S_CSUB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   stall;
	logic   leave_acc;
	logic   accept;

	// Hold in the accumulate state while a result cannot be placed
	assign stall     = (state_q == S_ACC) && st.idx_last && out_valid_q && !out_ready;
	assign leave_acc = (state_q == S_ACC) && !stall;
	assign in_ready  = (state_q == S_IDLE) || leave_acc;
	assign accept    = in_valid && in_ready;

	// Commands to the datapath
	always_comb begin
		cmd.accept   = accept;
		cmd.cmt_load = state_q == S_CHDR;
		cmd.cmt_lo   = state_q == S_CLO;
		cmd.cmt_step = state_q == S_CSUB;
		cmd.idx_mul  = state_q == S_IDX;
		cmd.idx_acc  = leave_acc;
		cmd.out_load = leave_acc && st.idx_last;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE, S_ACC: begin
					if (state_q == S_ACC && stall) begin
						state_q <= S_ACC;
					end else if (accept && st.kind == maag_pkg::KIND_CMT) begin
						state_q <= S_CHDR;
					end else if (accept && st.kind == maag_pkg::KIND_IDX) begin
						state_q <= S_IDX;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_IDX: begin
					state_q <= st.idx_live ? S_ACC : S_IDLE;
				end
				S_CHDR: begin
					state_q <= S_CLO;
				end
				S_CLO: begin
					state_q <= S_CSUB;
				end
				S_CSUB: begin
					state_q <= st.walk_end ? S_IDLE : S_CLO;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	`MAAG_ASSERT_NOW(a_busy_not_ready, clk, arst_n, (state_q == S_IDX || state_q == S_CHDR || state_q == S_CLO || state_q == S_CSUB), !in_ready, "ready raised during a walk or multiply")
	`MAAG_ASSERT_NOW(a_no_overwrite, clk, arst_n, cmd.out_load, (!out_valid_q || out_ready), "pending result overwritten")
	`MAAG_ASSERT_NEXT(a_commit_starts, clk, arst_n, (accept && st.kind == maag_pkg::KIND_CMT), (state_q == S_CHDR), "commit did not start its walk")
	`MAAG_ASSERT_NEXT(a_dead_index, clk, arst_n, (state_q == S_IDX && !st.idx_live), (state_q == S_IDLE && !cmd.out_load), "ignored index word went on")

endmodule

// File: rtl/core/multidim_array_address_generator_unit.sv
// Channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// input    | in_valid / in_ready   | opcode slot dim_position base_address elem_size
//          |                       | dim_count lower_bound upper_bound index_value
// output   | out_valid / out_ready | address
//
// Header and bound words are written when accepted; an index word goes through a
// descriptor read, then multiply into the shared product register, then accumulate.
// A commit walks the saturated dimension count d: it reads one bound pair from the
// bounds memory per dimension and does one offset multiply per step.
// Reset clears control state and the running address only; descriptor memories
// are not cleared. A stalled result stays in the output register while the next
// word is taken; only an index word that must emit waits for it to drain.
module multidim_array_address_generator_unit #(
	parameter int NUM_SLOTS = maag_pkg::NUM_SLOTS_DEF,
	parameter int MAX_DIMS  = maag_pkg::MAX_DIMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [3:0]         slot,
	input  logic [3:0]         dim_position,
	input  logic [30:0]        base_address,
	input  logic [15:0]        elem_size,
	input  logic [4:0]         dim_count,
	input  logic signed [15:0] lower_bound,
	input  logic signed [15:0] upper_bound,
	input  logic signed [15:0] index_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] address
);

	maag_pkg::dp_cmd_t    cmd;
	maag_pkg::dp_status_t st;

	maag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	maag_dpath #(.NUM_SLOTS(NUM_SLOTS), .MAX_DIMS(MAX_DIMS)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.slot         (slot),
		.dim_position (dim_position),
		.base_address (base_address),
		.elem_size    (elem_size),
		.dim_count    (dim_count),
		.lower_bound  (lower_bound),
		.upper_bound  (upper_bound),
		.index_value  (index_value),
		.cmd          (cmd),
		.st           (st),
		.address      (address)
	);

endmodule
